/* src/typed_key_hash_unit_assert.svh */
// Assertion macros for the typed key hash unit.
`ifndef TYPED_KEY_HASH_UNIT_ASSERT_SVH
`define TYPED_KEY_HASH_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TKH_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("typed_key_hash_unit: assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define TKH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("typed_key_hash_unit: assertion failed");

`endif

/* src/tkh_pkg.sv */
// Shared types, key codes and hash constants of the typed key hash unit.
package tkh_pkg;

	// Key kind codes carried on the kind port
	typedef enum logic [3:0] {
		KIND_INT32     = 4'd0,
		KIND_INT64     = 4'd1,
		KIND_DOUBLE    = 4'd2,
		KIND_FLOAT     = 4'd3,
		KIND_BOOL      = 4'd4,
		KIND_POINTER   = 4'd5,
		KIND_STR_BYTE  = 4'd6,
		KIND_EMPTY_STR = 4'd7,
		KIND_NULL_STR  = 4'd8
	} kind_t;

	// Hash constants
	localparam logic [63:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
	localparam logic [63:0] FNV_BASIS  = 64'hcbf2_9ce4_8422_2325;
	localparam logic [63:0] FNV_PRIME  = 64'h0000_0100_0000_01b3;
	localparam logic [31:0] BOOL_TRUE  = 32'd1231;
	localparam logic [31:0] BOOL_FALSE = 32'd1237;

	// How a request is handled by the datapath
	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_DIRECT,
		CLS_MIX,
		CLS_STR
	} item_cls_t;

	// Constant operand of the shared multiplier
	typedef enum logic [1:0] {
		K_A,
		K_B,
		K_P
	} mul_k_t;

	// Datapath operations
	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_MUL,
		DP_MIX_MID,
		DP_MIX_END,
		DP_STR_MID,
		DP_STR_END
	} dp_op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_SUM_A,
		ST_MUL_B,
		ST_SUM_B,
		ST_MUL_P,
		ST_SUM_P
	} state_t;

	// Controller to datapath
	typedef struct packed {
		dp_op_t op;
		mul_k_t k;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		item_cls_t cls;
		logic      last;
	} dp_status_t;

endpackage

/* src/tkh_dpath.sv */
// Datapath of the typed key hash unit: key decode, shared 64-bit multiplier, FNV state.
module tkh_dpath import tkh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [3:0]         kind,
	input  logic [63:0]        key_bits,
	input  logic [7:0]         string_byte,
	input  logic               first_byte,
	input  logic               last_byte,
	output dp_status_t         status,
	output logic signed [31:0] hash_value
);

	logic [63:0]        acc_q;
	logic [63:0]        x_q;
	logic [63:0]        pp_ll_q;
	logic [31:0]        pp_lh_q;
	logic [31:0]        pp_hl_q;
	logic signed [31:0] hash_q;

	item_cls_t   cls;
	logic [63:0] mix_in;
	logic [63:0] mix_pre;
	logic [63:0] str_x;
	logic [31:0] direct_val;
	logic [63:0] k_op;
	logic [63:0] ll_full;
	logic [63:0] lh_full;
	logic [63:0] hl_full;
	logic [31:0] cross_sum;
	logic [63:0] prod;
	logic [63:0] mix_mid;
	logic [63:0] mix_fin;

	// Decode the key kind into a handling class and operand
	always_comb begin
		cls        = CLS_NONE;
		mix_in     = key_bits;
		direct_val = '0;
		unique case (kind)
			KIND_INT32: begin
				cls    = CLS_MIX;
				mix_in = {{32{key_bits[31]}}, key_bits[31:0]};
			end
			KIND_INT64, KIND_POINTER: begin
				cls = CLS_MIX;
			end
			KIND_DOUBLE: begin
				// plus and minus zero hash to zero
				cls = (key_bits[62:0] == '0) ? CLS_DIRECT : CLS_MIX;
			end
			KIND_FLOAT: begin
				cls    = (key_bits[30:0] == '0) ? CLS_DIRECT : CLS_MIX;
				mix_in = {32'd0, key_bits[31:0]};
			end
			KIND_BOOL: begin
				cls        = CLS_DIRECT;
				direct_val = (key_bits[7:0] != '0) ? BOOL_TRUE : BOOL_FALSE;
			end
			KIND_STR_BYTE: begin
				cls = CLS_STR;
			end
			KIND_EMPTY_STR: begin
				cls        = CLS_DIRECT;
				direct_val = FNV_BASIS[31:0];
			end
			KIND_NULL_STR: begin
				cls = CLS_DIRECT;
			end
			default: begin
				cls = CLS_NONE;
			end
		endcase
	end

	assign mix_pre = mix_in ^ (mix_in >> 30);
	assign str_x   = (first_byte ? FNV_BASIS : acc_q) ^ {56'd0, string_byte};

	assign status.cls  = cls;
	assign status.last = last_byte;

	// Select the multiplier constant
	always_comb begin
		unique case (cmd.k)
			K_A:     k_op = MIX_MUL_A;
			K_B:     k_op = MIX_MUL_B;
			K_P:     k_op = FNV_PRIME;
			default: k_op = FNV_PRIME;
		endcase
	end

	// Form the partial products of a 64x64 multiply modulo 2^64
	assign ll_full = {32'd0, x_q[31:0]} * {32'd0, k_op[31:0]};
	assign lh_full = {32'd0, x_q[31:0]} * {32'd0, k_op[63:32]};
	assign hl_full = {32'd0, x_q[63:32]} * {32'd0, k_op[31:0]};

	// Combine the registered partial products
	assign cross_sum = pp_lh_q + pp_hl_q;
	assign prod      = pp_ll_q + {cross_sum, 32'd0};
	assign mix_mid   = prod ^ (prod >> 27);
	assign mix_fin   = prod ^ (prod >> 31);

	// Hold the string accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= FNV_BASIS;
		end else if (cmd.op == DP_STR_MID) begin
			acc_q <= prod;
		end else if (cmd.op == DP_STR_END) begin
			acc_q <= FNV_BASIS;
		end
	end

	// Advance operand, partial products and result
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				if (cls == CLS_MIX) begin
					x_q <= mix_pre;
				end
				if (cls == CLS_STR) begin
					x_q <= str_x;
				end
				if (cls == CLS_DIRECT) begin
					hash_q <= direct_val;
				end
			end
			DP_MUL: begin
				pp_ll_q <= ll_full;
				pp_lh_q <= lh_full[31:0];
				pp_hl_q <= hl_full[31:0];
			end
			DP_MIX_MID: begin
				x_q <= mix_mid;
			end
			DP_MIX_END: begin
				hash_q <= mix_fin[31:0];
			end
			DP_STR_END: begin
				hash_q <= prod[31:0];
			end
			DP_NOP, DP_STR_MID: begin
			end
			default: begin
			end
		endcase
	end

	assign hash_value = hash_q;

endmodule

/* src/tkh_ctrl.sv */
// Controller of the typed key hash unit: request sequencing and result handshake.
module tkh_ctrl import tkh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   last_q;
	logic   out_valid_q;
	logic   out_free;
	logic   in_accept;
	logic   result_load;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_accept = in_valid && !in_stall;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && status.cls == CLS_MIX) begin
					state_nxt = ST_MUL_A;
				end else if (in_accept && status.cls == CLS_STR) begin
					state_nxt = ST_MUL_P;
				end
			end
			ST_MUL_A: state_nxt = ST_SUM_A;
			ST_SUM_A: state_nxt = ST_MUL_B;
			ST_MUL_B: state_nxt = ST_SUM_B;
			ST_SUM_B: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_MUL_P: state_nxt = ST_SUM_P;
			ST_SUM_P: begin
				if (!last_q || out_free) begin
					state_nxt = ST_IDLE;
				end
			end
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		in_stall    = 1'b1;
		cmd.op      = DP_NOP;
		cmd.k       = K_P;
		result_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = out_valid_q && out_stall;
				if (in_valid && !(out_valid_q && out_stall)) begin
					cmd.op      = DP_LOAD;
					result_load = (status.cls == CLS_DIRECT);
				end
			end
			ST_MUL_A: begin
				cmd.op = DP_MUL;
				cmd.k  = K_A;
			end
			ST_SUM_A: begin
				cmd.op = DP_MIX_MID;
			end
			ST_MUL_B: begin
				cmd.op = DP_MUL;
				cmd.k  = K_B;
			end
			ST_SUM_B: begin
				if (out_free) begin
					cmd.op      = DP_MIX_END;
					result_load = 1'b1;
				end
			end
			ST_MUL_P: begin
				cmd.op = DP_MUL;
				cmd.k  = K_P;
			end
			ST_SUM_P: begin
				if (!last_q) begin
					cmd.op = DP_STR_MID;
				end else if (out_free) begin
					cmd.op      = DP_STR_END;
					result_load = 1'b1;
				end
			end
		endcase
	end

	// Hold state, last flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= result_load || (out_valid_q && out_stall);
			if (in_accept) begin
				last_q <= status.last;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/typed_key_hash_unit.sv */
// Top level of the typed key hash unit.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------------
//  in      | in_valid / in_stall | kind, key_bits, string_byte, first_byte, last_byte
//  out     | out_valid/out_stall | hash_value
//
// Bool, signed-zero float and double, empty and null string results load on accept.
// Mixes pass MUL_A/SUM_A/MUL_B/SUM_B, bytes MUL_P/SUM_P: one shared 64x64 multiply
// (three 32x32 partial products, then a sum) is used twice per mix and once per byte.
// Reset sets the string accumulator to the FNV-1a offset basis at once.
// A stalled result holds in_stall high until it is taken.
`include "typed_key_hash_unit_assert.svh"
module typed_key_hash_unit import tkh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         kind,
	input  logic [63:0]        key_bits,
	input  logic [7:0]         string_byte,
	input  logic               first_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] hash_value
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_take;
	logic       bool_hash;
	logic       result_op;

	// Sequence requests
	tkh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Compute hashes
	tkh_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.key_bits    (key_bits),
		.string_byte (string_byte),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.status      (status),
		.hash_value  (hash_value)
	);

	// Terms used by the checks
	assign in_take   = in_valid && !in_stall;
	assign bool_hash = (hash_value == BOOL_TRUE) || (hash_value == BOOL_FALSE);
	assign result_op = (cmd.op == DP_MIX_END) || (cmd.op == DP_STR_END);

	`TKH_ASSERT_NEXT(a_bool_result, in_take && kind == KIND_BOOL, out_valid && bool_hash)
	`TKH_ASSERT_NEXT(a_null_result, in_take && kind == KIND_NULL_STR, out_valid && hash_value == '0)
	`TKH_ASSERT_NEXT(a_mix_starts, in_take && kind == KIND_INT64, cmd.op == DP_MUL)
	`TKH_ASSERT_SAME(a_end_output_free, result_op, !out_valid || !out_stall)

endmodule
